[src/rkdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob debounce package
// Shared types and constants for the knob debounce and direction qualifier.
// ----------------------------------------------------------------------------
package rkdd_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CNT_W           = 8;
	localparam int STABLE_W        = 8;
	localparam int HOLDOFF_W       = 16;
	localparam int CFG_DATA_W      = 16;

	localparam logic [STABLE_W-1:0]  STABLE_RESET  = 8'd8;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd150;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_STABLE  = 1'b0,
		CFG_HOLDOFF = 1'b1
	} cfg_idx_t;

	// Last decided direction.
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic a_edge_seen;
		logic pin_b;
		logic pin_a;
	} item_t;

	typedef struct packed {
		logic qualifier_busy;
		logic step_direction;
		logic event_valid;
	} result_t;

endpackage

[src/rkdd_qual.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob qualifier core
// Holds the debounce state and computes one result per processed item.
// ----------------------------------------------------------------------------
module rkdd_qual import rkdd_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  item_t                item,
	input  logic [STABLE_W-1:0]  stable_periods,
	input  logic [HOLDOFF_W-1:0] holdoff_periods,
	output result_t              res
);

	localparam int CMP_W = (TIMER_WIDTH > HOLDOFF_W) ? TIMER_WIDTH : HOLDOFF_W;

	logic                   armed_q, have_sample_q;
	logic [CNT_W-1:0]       count_q;
	logic                   held_a_q, held_b_q;
	dir_t                   last_dir_q;
	logic [TIMER_WIDTH-1:0] timer_q;

	logic                   armed_d, have_sample_d;
	logic [CNT_W-1:0]       count_d, cnt_inc;
	logic                   held_a_d, held_b_d;
	dir_t                   last_dir_d, dir;
	logic [TIMER_WIDTH-1:0] timer_inc, timer_d;
	logic                   ev, dir_bit, late;

	assign timer_inc = (timer_q == {TIMER_WIDTH{1'b1}}) ? timer_q : timer_q + 1'b1;
	assign cnt_inc   = (count_q == {CNT_W{1'b1}}) ? count_q : count_q + 1'b1;
	assign dir       = (held_a_q != held_b_q) ? DIR_UP : DIR_DOWN;
	assign late      = CMP_W'(timer_inc) > CMP_W'(holdoff_periods);

	always_comb begin
		armed_d       = armed_q;
		have_sample_d = have_sample_q;
		count_d       = count_q;
		held_a_d      = held_a_q;
		held_b_d      = held_b_q;
		last_dir_d    = last_dir_q;
		timer_d       = timer_inc;
		ev            = 1'b0;
		dir_bit       = 1'b0;
		if (!armed_q) begin
			armed_d = item.a_edge_seen;
		end else if (!have_sample_q) begin
			have_sample_d = 1'b1;
			count_d       = CNT_W'(1);
			held_a_d      = item.pin_a;
			held_b_d      = item.pin_b;
		end else begin
			count_d = cnt_inc;
			if (item.pin_a != held_a_q || item.pin_b != held_b_q) begin
				armed_d       = 1'b0;
				have_sample_d = 1'b0;
				count_d       = '0;
				held_a_d      = 1'b0;
				held_b_d      = 1'b0;
			end else if (cnt_inc >= stable_periods) begin
				if (dir == last_dir_q || late) begin
					ev      = 1'b1;
					dir_bit = (dir == DIR_DOWN);
				end
				last_dir_d    = dir;
				timer_d       = '0;
				armed_d       = 1'b0;
				have_sample_d = 1'b0;
				count_d       = '0;
				held_a_d      = 1'b0;
				held_b_d      = 1'b0;
			end
		end
	end

	assign res.event_valid    = ev;
	assign res.step_direction = dir_bit;
	assign res.qualifier_busy = armed_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			have_sample_q <= 1'b0;
			count_q       <= '0;
			held_a_q      <= 1'b0;
			held_b_q      <= 1'b0;
			last_dir_q    <= DIR_NONE;
			timer_q       <= '1;
		end else if (en) begin
			armed_q       <= armed_d;
			have_sample_q <= have_sample_d;
			count_q       <= count_d;
			held_a_q      <= held_a_d;
			held_b_q      <= held_b_d;
			last_dir_q    <= last_dir_d;
			timer_q       <= timer_d;
		end
	end

endmodule

[src/rotary_knob_debounce_direction_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob debounce and direction qualifier
// Streams one sampled pin pair per debounce period and returns one result
// item per input item telling whether a qualified knob step occurred.
// ----------------------------------------------------------------------------
// Feed one input item per debounce period; every input item yields exactly one
// result item, in order. An input item is registered on acceptance and
// processed as it moves into the result register. The block sustains
// one item per cycle: a new item is taken while the previous result
// waits, and the input register only stalls when the result register
// is full and not being taken. An edge on channel A arms the
// qualifier, the following item latches the pin
// pair, and once the pins have matched for stable_periods items a
// direction is decided (up when A differs from B). The step is reported
// when it repeats the previous direction, or when more than
// holdoff_periods items have passed since the previous decision; the
// elapsed timer saturates at all ones. Configuration is written through
// cfg_we/cfg_index/cfg_data and should only change while no item is in
// flight.
// ----------------------------------------------------------------------------
module rotary_knob_debounce_direction_top import rkdd_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input item stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] pin_a, [1] pin_b, [2] a_edge_seen
	// Result item stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [0] event_valid, [1] step_direction,
	                                         // [2] qualifier_busy
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [STABLE_W-1:0]  stable_q;
	logic [HOLDOFF_W-1:0] holdoff_q;

	// Configuration registers; index 0 is the stable count, index 1 the holdoff.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q  <= STABLE_RESET;
			holdoff_q <= HOLDOFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STABLE:  stable_q  <= cfg_data[STABLE_W-1:0];
				CFG_HOLDOFF: holdoff_q <= cfg_data[HOLDOFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register and its valid flag.
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t res;

	// The registered item moves on whenever the result register can take it.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata[2:0]);
		end
	end

	// Debounce state advances exactly once per item, as it enters the result register.
	rkdd_qual #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_qual (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.item            (item_s1),
		.stable_periods  (stable_q),
		.holdoff_periods (holdoff_q),
		.res             (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {5'b0, res};
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob debounce and direction qualifier testbench
// Drives pin samples through the input stream and predicts every result
// item from a cycle-free model of the qualifier. Directed tasks cover the
// first decision, aborts, edges while armed, the smallest thresholds and
// the holdoff extremes. Random strokes follow under three idling patterns
// and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
	import rkdd_pkg::*;

	localparam int TW = TIMER_WIDTH_DEF;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;    // [0] pin_a, [1] pin_b, [2] a_edge_seen
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;    // [0] event_valid, [1] step_direction,
	                                   // [2] qualifier_busy
	logic                  cfg_we;
	logic [0:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rotary_knob_debounce_direction_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Percent of cycles in which the sender holds back an item, and in which
	// the receiver refuses one.
	int src_idle_pct  = 24;
	int sink_idle_pct = 74;

	// Bookkeeping for the summary and the verdict.
	int n_items   = 0;
	int n_results = 0;
	int n_events  = 0;
	int n_down    = 0;
	int n_fail    = 0;

	// Results still owed by the block, oldest first.
	result_t expected_results[$];

	// Our own copy of the registers and of the qualifier state.
	logic [STABLE_W-1:0]  stable_cfg;
	logic [HOLDOFF_W-1:0] holdoff_cfg;
	logic                 knob_armed;
	logic                 knob_sampled;
	logic [CNT_W-1:0]     stable_count;
	logic                 held_a;
	logic                 held_b;
	dir_t                 last_dir;
	logic [TW-1:0]        since_decision;

	initial begin
		stable_cfg     = STABLE_RESET;
		holdoff_cfg    = HOLDOFF_RESET;
		knob_armed     = 1'b0;
		knob_sampled   = 1'b0;
		stable_count   = '0;
		held_a         = 1'b0;
		held_b         = 1'b0;
		last_dir       = DIR_NONE;
		since_decision = '1;
	end

	// Drops the qualifier back to idle; used on an abort and after a decision.
	function automatic void drop_qualifier();
		knob_armed   = 1'b0;
		knob_sampled = 1'b0;
		stable_count = '0;
		held_a       = 1'b0;
		held_b       = 1'b0;
	endfunction

	// Advances the qualifier by one debounce period and returns the result
	// item the block owes for it.
	function automatic result_t predict_step(input item_t it);
		result_t r;
		dir_t    d;
		r = '0;
		// The elapsed timer moves first and saturates at all ones.
		if (since_decision != '1)
			since_decision = since_decision + 1'b1;
		if (!knob_armed) begin
			// Only an edge matters while idle; the pins are not sampled yet.
			if (it.a_edge_seen)
				knob_armed = 1'b1;
		end else if (!knob_sampled) begin
			knob_sampled = 1'b1;
			stable_count = CNT_W'(1);
			held_a       = it.pin_a;
			held_b       = it.pin_b;
		end else begin
			if (stable_count != '1)
				stable_count = stable_count + 1'b1;
			if (it.pin_a != held_a || it.pin_b != held_b) begin
				drop_qualifier();
			end else if (stable_count >= stable_cfg) begin
				d = (held_a != held_b) ? DIR_UP : DIR_DOWN;
				// A repeat is always reported, a reversal only after the holdoff.
				if (d == last_dir || since_decision > TW'(holdoff_cfg)) begin
					r.event_valid    = 1'b1;
					r.step_direction = (d == DIR_DOWN);
				end
				last_dir       = d;
				since_decision = '0;
				drop_qualifier();
			end
		end
		r.qualifier_busy = knob_armed;
		return r;
	endfunction

	// Offers one item and predicts its result once the block has taken it.
	// The valid stays high on return so that back-to-back items need no gap.
	task automatic send_item(input logic a, input logic b, input logic a_edge);
		item_t it;
		it.pin_a       = a;
		it.pin_b       = b;
		it.a_edge_seen = a_edge;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, it};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_results.push_back(predict_step(it));
		n_items++;
	endtask

	// Stops offering items and waits until every owed result has come, then
	// idles on so that nothing is left in the pipeline.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes happen only with the block drained.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_STABLE: begin
				stable_cfg = value[STABLE_W-1:0];
			end
			CFG_HOLDOFF: begin
				holdoff_cfg = value[HOLDOFF_W-1:0];
			end
		endcase
	endtask

	// One knob detent as the pins would show it: an arming edge, the latch
	// period and a run of matching periods long enough for a decision. A
	// short run leaves the qualifier armed for the next stroke, and a broken
	// stroke flips one pin somewhere in the run.
	task automatic send_stroke(input bit broken);
		logic a, b;
		int   run_len, break_at;
		a = 1'($urandom_range(1));
		b = 1'($urandom_range(1));
		run_len = (stable_cfg > 2 ? int'(stable_cfg) : 2) - 1;
		if ($urandom_range(99) < 15)
			run_len = $urandom_range(run_len, 0);
		break_at = broken ? $urandom_range(run_len, 0) : -1;
		send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
		send_item(a, b, 1'($urandom_range(1)));
		for (int i = 0; i < run_len; i++) begin
			if (i == break_at) begin
				if ($urandom_range(1))
					send_item(~a, b, 1'($urandom_range(1)));
				else
					send_item(a, ~b, 1'($urandom_range(1)));
			end else begin
				send_item(a, b, 1'($urandom_range(1)));
			end
		end
	endtask

	// Sets both registers, then sends mostly well-formed strokes mixed with
	// random pin noise until the budget of items is spent.
	task automatic random_segment(input logic [CFG_DATA_W-1:0] stable,
	                              input logic [CFG_DATA_W-1:0] holdoff,
	                              input int budget);
		int stop_at;
		int n;
		write_reg(CFG_STABLE, stable);
		write_reg(CFG_HOLDOFF, holdoff);
		stop_at = n_items + budget;
		while (n_items < stop_at) begin
			if ($urandom_range(99) < 70) begin
				send_stroke($urandom_range(99) < 20);
			end else begin
				n = $urandom_range(6, 1);
				repeat (n)
					send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
					          1'($urandom_range(1)));
			end
		end
	endtask

	// With the reset settings the very first decision is reported, since the
	// saturated timer is far past the holdoff. An edge in the latch period
	// and in the counting periods must not restart the sequence.
	task automatic test_first_step();
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b0, 1'b1, 1'b1);
		for (int i = 0; i < 7; i++)
			send_item(1'b0, 1'b1, i[0]);
	endtask

	// A pin that moves after the latch sends the qualifier back to idle, and
	// an idle period without an edge leaves it there.
	task automatic test_abort();
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b0, 1'b0, 1'b0);
	endtask

	// A threshold of zero decides in the first period after the latch. The
	// upper data bits of the write must be dropped. With the holdoff at its
	// maximum the reversal stays silent while the repeat is reported.
	task automatic test_threshold_zero();
		write_reg(CFG_STABLE, 16'hFF00);
		write_reg(CFG_HOLDOFF, 16'hFFFF);
		send_item(1'b0, 1'b1, 1'b1);
		send_item(1'b1, 1'b1, 1'b0);
		send_item(1'b1, 1'b1, 1'b0);
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b0, 1'b0, 1'b1);
		send_item(1'b0, 1'b0, 1'b1);
	endtask

	// With no holdoff any reversal is reported at once.
	task automatic test_holdoff_zero();
		write_reg(CFG_STABLE, 16'h0001);
		write_reg(CFG_HOLDOFF, 16'h0000);
		send_item(1'b0, 1'b0, 1'b1);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b0);
	endtask

	// Random strokes under the three idling patterns, each with its own
	// register settings: the threshold runs from zero-like small values up
	// to its maximum, the holdoff from zero up to the timer limit.
	task automatic test_random_traffic();
		src_idle_pct  = 24;
		sink_idle_pct = 74;
		random_segment(16'd2, 16'd5, 180);
		random_segment(16'd255, 16'd300, 260);
		wait_drained();
		src_idle_pct  = 74;
		sink_idle_pct = 24;
		random_segment(16'd1, 16'd0, 180);
		random_segment(16'd6, 16'd20, 180);
		wait_drained();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		random_segment(16'd3, 16'hFFFF, 180);
		random_segment(16'd8, 16'd150, 180);
	endtask

	// Result checker. It also draws the receiver's ready for the next cycle,
	// so a stall can fall on any phase of the block's work.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[2:0];
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected: %b", m_tdata);
				n_fail++;
			end else begin
				want = expected_results.pop_front();
				n_results++;
				if (got.event_valid !== want.event_valid) begin
					$error("event_valid: expected %b, actual %b",
					       want.event_valid, got.event_valid);
					n_fail++;
				end
				if (got.step_direction !== want.step_direction) begin
					$error("step_direction: expected %b, actual %b",
					       want.step_direction, got.step_direction);
					n_fail++;
				end
				if (got.qualifier_busy !== want.qualifier_busy) begin
					$error("qualifier_busy: expected %b, actual %b",
					       want.qualifier_busy, got.qualifier_busy);
					n_fail++;
				end
				if (want.event_valid) begin
					n_events++;
					if (want.step_direction)
						n_down++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Main sequence: reset once, directed checks, then random traffic.
	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_STABLE;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_step();
		test_abort();
		test_threshold_zero();
		test_holdoff_zero();
		test_random_traffic();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d items and checked %0d results under three idling patterns.",
		         n_items, n_results);
		$display("Reported %0d knob steps (%0d down), %0d mismatches.",
		         n_events, n_down, n_fail);
		if (n_fail == 0)
			$display("PASS rotary_knob_debounce_direction_top");
		else
			$display("FAIL rotary_knob_debounce_direction_top");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin
		#2_000_000;
		$display("FAIL rotary_knob_debounce_direction_top");
		$finish;
	end

endmodule
